### rtl/core/brf_pkg.sv
package brf_pkg;

  localparam int CAPACITY       = 256;
  localparam int MAX_ITEM_BYTES = 8;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int POS_W  = IDX_W + 1;
  localparam int NB_W   = $clog2(MAX_ITEM_BYTES + 1);
  localparam int LANE_W = (MAX_ITEM_BYTES > 1) ? $clog2(MAX_ITEM_BYTES) : 1;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 32;

  localparam int HIGH_DEFAULT = CAPACITY * 8 / 10;
  localparam int LOW_DEFAULT  = CAPACITY * 2 / 10;

  // operation codes
  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_PEEK     = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_SHUTDOWN = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BLOCK   = 3'd3;
  localparam logic [2:0] ST_EOF     = 3'd4;
  localparam logic [2:0] ST_CANCEL  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_ITEM_BYTES = 3'd0;
  localparam logic [2:0] REG_DROP_FULL  = 3'd1;
  localparam logic [2:0] REG_LOCKED     = 3'd2;
  localparam logic [2:0] REG_HIGH_MARK  = 3'd3;
  localparam logic [2:0] REG_LOW_MARK   = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [POS_W-1:0]  used_bytes;
    logic              backpressure;
    logic [CNT_W-1:0]  written_count;
    logic [CNT_W-1:0]  read_count;
    logic [CNT_W-1:0]  drop_count;
    logic [CNT_W-1:0]  underflow_count;
    logic [POS_W-1:0]  peak_bytes;
  } out_word_t;

  typedef struct packed {
    logic              latch;
    logic              wr_en;
    logic              rd_en;
    logic              finish;
    logic [LANE_W-1:0] lane;
  } brf_cmd_t;

  typedef struct packed {
    logic            write_go;
    logic            fetch_go;
    logic [NB_W-1:0] n;
  } brf_stat_t;

endpackage

### rtl/core/brf_ctrl.sv
module brf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              cfg_ready,
  input  brf_pkg::brf_stat_t st,
  output brf_pkg::brf_cmd_t  cmd
);
  import brf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]        state, state_next;
  logic [LANE_W-1:0] cnt, cnt_next;
  logic              last_lane;
  logic              out_free;

  assign last_lane = ({{(NB_W - LANE_W){1'b0}}, cnt} == st.n - NB_W'(1));
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.lane   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cnt_next = '0;
        if (st.write_go) begin
          state_next = S_WRITE;
        end else if (st.fetch_go) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        cnt_next  = cnt + LANE_W'(1);
        if (last_lane) begin
          state_next = S_FINISH;
        end
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        cnt_next  = cnt + LANE_W'(1);
        if (last_lane) begin
          state_next = S_DRAIN;
        end
      end
      // last byte lands in the accumulator here
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EVAL)
    else $error("accepted word did not move to evaluation");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && state == S_IDLE)
    else $error("finished word not presented");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE || state == S_FETCH) |->
      ({{(NB_W - LANE_W){1'b0}}, cnt} < st.n))
    else $error("byte lane beyond item size");

endmodule

### rtl/core/brf_datapath.sv
module brf_datapath (
  input  logic               clk,
  input  logic               rst,
  input  brf_pkg::in_word_t  in_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  brf_pkg::brf_cmd_t  cmd,
  output brf_pkg::brf_stat_t st,
  output brf_pkg::out_word_t out_data
);
  import brf_pkg::*;

  logic [7:0] mem [CAPACITY];

  // configuration
  logic [3:0]       item_bytes;
  logic             drop_when_full;
  logic             locked_mode;
  logic [POS_W-1:0] high_mark;
  logic [POS_W-1:0] low_mark;

  // ring state
  logic [POS_W-1:0] write_pos, write_pos_next;
  logic [POS_W-1:0] read_pos, read_pos_next;
  logic             pressure, pressure_next;
  logic             shut, shut_next;
  logic [CNT_W-1:0] items_in, items_in_next;
  logic [CNT_W-1:0] items_out, items_out_next;
  logic [CNT_W-1:0] drops, drops_next;
  logic [CNT_W-1:0] underflows, underflows_next;
  logic [POS_W-1:0] peak, peak_next;

  // current word
  in_word_t          word_q;
  logic [DATA_W-1:0] rd_acc;
  logic [7:0]        mem_q;
  logic              rd_pend;
  logic [LANE_W-1:0] rd_lane;

  logic [NB_W-1:0]  n;
  logic [POS_W-1:0] hi, lo, used, used_after;
  logic [POS_W:0]   need;
  logic             room, have, invalid;
  logic [2:0]       status;
  logic             give_data;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  assign n    = (item_bytes > 4'(MAX_ITEM_BYTES)) ? NB_W'(MAX_ITEM_BYTES) : NB_W'(item_bytes);
  assign hi   = (high_mark != '0) ? high_mark : POS_W'(HIGH_DEFAULT);
  assign lo   = (low_mark != '0) ? low_mark : POS_W'(LOW_DEFAULT);
  assign used = write_pos - read_pos;
  assign need = {1'b0, used} + (POS_W + 1)'(n);
  assign room = (need <= (POS_W + 1)'(CAPACITY));
  assign have = (used >= POS_W'(n));
  assign invalid = (n == '0) || (word_q.op > OP_SHUTDOWN);

  assign st.n        = n;
  assign st.write_go = !invalid && (word_q.op == OP_WRITE) && room;
  assign st.fetch_go = !invalid && (word_q.op == OP_READ || word_q.op == OP_PEEK) && have;

  assign wr_addr = write_pos[IDX_W-1:0] + IDX_W'(cmd.lane);
  assign rd_addr = read_pos[IDX_W-1:0] + IDX_W'(cmd.lane);

  always_comb begin
    write_pos_next  = write_pos;
    read_pos_next   = read_pos;
    pressure_next   = pressure;
    shut_next       = shut;
    items_in_next   = items_in;
    items_out_next  = items_out;
    drops_next      = drops;
    underflows_next = underflows;
    peak_next       = peak;
    status          = ST_OK;
    give_data       = 1'b0;
    used_after      = used;
    if (invalid) begin
      status = ST_INVALID;
    end else begin
      unique case (word_q.op)
        OP_WRITE: begin
          if (!room) begin
            if (locked_mode && shut) begin
              status = ST_CANCEL;
            end else if (drop_when_full) begin
              drops_next = drops + CNT_W'(1);
              status     = ST_FULL;
            end else begin
              status = ST_BLOCK;
            end
          end else begin
            write_pos_next = write_pos + POS_W'(n);
            items_in_next  = items_in + CNT_W'(1);
            used_after     = used + POS_W'(n);
            if (locked_mode) begin
              if (used_after > peak) begin
                peak_next = used_after;
              end
              if (used_after >= hi) begin
                pressure_next = 1'b1;
              end
            end
          end
        end
        OP_READ: begin
          if (!have) begin
            if (locked_mode) begin
              status = shut ? ST_CANCEL : ST_BLOCK;
            end else begin
              underflows_next = underflows + CNT_W'(1);
              status          = ST_EOF;
            end
          end else begin
            give_data      = 1'b1;
            read_pos_next  = read_pos + POS_W'(n);
            items_out_next = items_out + CNT_W'(1);
            used_after     = used - POS_W'(n);
            if (locked_mode && used_after <= lo) begin
              pressure_next = 1'b0;
            end
          end
        end
        OP_PEEK: begin
          if (!have) begin
            status = ST_EOF;
          end else begin
            give_data = 1'b1;
          end
        end
        OP_CLEAR: begin
          write_pos_next = '0;
          read_pos_next  = '0;
          pressure_next  = 1'b0;
          used_after     = '0;
        end
        default: begin
          shut_next = 1'b1;
        end
      endcase
    end
  end

  // byte store, one byte per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= word_q.write_data[cmd.lane*8 +: 8];
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      word_q <= in_data;
      rd_acc <= '0;
    end else if (rd_pend) begin
      rd_acc[rd_lane*8 +: 8] <= mem_q;
    end
    rd_lane <= cmd.lane;
    if (cmd.finish) begin
      out_data.status          <= status;
      out_data.read_data       <= give_data ? rd_acc : '0;
      out_data.used_bytes      <= used_after;
      out_data.backpressure    <= pressure_next;
      out_data.written_count   <= items_in_next;
      out_data.read_count      <= items_out_next;
      out_data.drop_count      <= drops_next;
      out_data.underflow_count <= underflows_next;
      out_data.peak_bytes      <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend        <= 1'b0;
      item_bytes     <= 4'd4;
      drop_when_full <= 1'b0;
      locked_mode    <= 1'b0;
      high_mark      <= POS_W'(HIGH_DEFAULT);
      low_mark       <= POS_W'(LOW_DEFAULT);
      write_pos      <= '0;
      read_pos       <= '0;
      pressure       <= 1'b0;
      shut           <= 1'b0;
      items_in       <= '0;
      items_out      <= '0;
      drops          <= '0;
      underflows     <= '0;
      peak           <= '0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ITEM_BYTES: item_bytes     <= cfg_data[3:0];
          REG_DROP_FULL:  drop_when_full <= cfg_data[0];
          REG_LOCKED:     locked_mode    <= cfg_data[0];
          REG_HIGH_MARK:  high_mark      <= cfg_data[POS_W-1:0];
          REG_LOW_MARK:   low_mark       <= cfg_data[POS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        write_pos  <= write_pos_next;
        read_pos   <= read_pos_next;
        pressure   <= pressure_next;
        shut       <= shut_next;
        items_in   <= items_in_next;
        items_out  <= items_out_next;
        drops      <= drops_next;
        underflows <= underflows_next;
        peak       <= peak_next;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= POS_W'(CAPACITY))
    else $error("ring holds more than its capacity");

  a_shut_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(shut) && !$past(rst) |-> shut)
    else $error("shutdown flag cleared");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.finish) && !$past(rst) |-> $stable(write_pos) && $stable(read_pos))
    else $error("ring positions moved outside finish");

endmodule

### rtl/core/byte_ring_fifo_watermark.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data   (op, write_data)
// out     | output    | out_valid / out_ready | out_data  (status .. peak_bytes)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a word steps through idle, evaluation, one write or fetch step per byte
// (a drain step follows the fetches) and finish, the byte steps being set by
// the single byte port of the ring store, one byte per cycle
// reset clears positions, flags and counters and loads the config defaults;
// store contents stay undefined
// a result waits in the output register; the next word is taken meanwhile
// and holds in its finish cycle until that register is free
module byte_ring_fifo_watermark (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  brf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output brf_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  import brf_pkg::*;

  brf_cmd_t  cmd;
  brf_stat_t st;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  brf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import brf_pkg::*;

  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int NPHASE      = 10;
  localparam int NPLAN       = 29;
  localparam int TIMEOUT_NS  = 10_000_000;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [3:0] NO_STATUS   = 4'hF;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BOTH, MIX_NOISE} mix_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  code;
    logic [63:0] val;
    logic [3:0]  want;
  } step_t;

  typedef struct packed {
    logic [3:0] fixed;
    out_word_t  word;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic [3:0] in_fixed = NO_STATUS;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic      choke = 1'b0;

  always #6 clk = ~clk;

  byte_ring_fifo_watermark dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // directed walk: item rows carry op and data, register rows index and value
  step_t plan [NPLAN] = '{
    '{1'b0, OP_READ,        64'd0,                  4'(ST_EOF)},
    '{1'b0, OP_PEEK,        64'd0,                  4'(ST_EOF)},
    '{1'b0, OP_SPARE_LO,    64'd0,                  4'(ST_INVALID)},
    '{1'b0, OP_SPARE_HI,    64'hFFFF_FFFF_FFFF_FFFF, 4'(ST_INVALID)},
    '{1'b0, OP_WRITE,       64'hFFFF_FFFF_FFFF_FFFF, 4'(ST_OK)},
    '{1'b0, OP_WRITE,       64'h0123_4567_89AB_CDEF, 4'(ST_OK)},
    '{1'b0, OP_PEEK,        64'd0,                  NO_STATUS},
    '{1'b0, OP_READ,        64'd0,                  NO_STATUS},
    '{1'b0, OP_READ,        64'd0,                  NO_STATUS},
    '{1'b0, OP_READ,        64'd0,                  4'(ST_EOF)},
    '{1'b0, OP_CLEAR,       64'd0,                  4'(ST_OK)},
    '{1'b1, REG_ITEM_BYTES, 64'd0,                  NO_STATUS},
    '{1'b0, OP_WRITE,       64'hA5A5_A5A5_A5A5_A5A5, 4'(ST_INVALID)},
    '{1'b0, OP_CLEAR,       64'd0,                  4'(ST_INVALID)},
    '{1'b0, OP_SHUTDOWN,    64'd0,                  4'(ST_INVALID)},
    '{1'b0, OP_READ,        64'd0,                  4'(ST_INVALID)},
    '{1'b1, REG_ITEM_BYTES, 64'd15,                 NO_STATUS},
    '{1'b1, REG_LOCKED,     64'd1,                  NO_STATUS},
    '{1'b1, REG_HIGH_MARK,  64'd16,                 NO_STATUS},
    '{1'b1, REG_LOW_MARK,   64'd8,                  NO_STATUS},
    '{1'b0, OP_WRITE,       64'hFFFF_FFFF_FFFF_FFFF, NO_STATUS},
    '{1'b0, OP_WRITE,       64'h8000_0001_7FFF_FFFE, NO_STATUS},
    '{1'b0, OP_PEEK,        64'd0,                  NO_STATUS},
    '{1'b0, OP_READ,        64'd0,                  NO_STATUS},
    '{1'b0, OP_READ,        64'd0,                  NO_STATUS},
    '{1'b0, OP_READ,        64'd0,                  4'(ST_BLOCK)},
    '{1'b0, OP_PEEK,        64'd0,                  4'(ST_EOF)},
    '{1'b0, OP_WRITE,       64'd0,                  NO_STATUS},
    '{1'b0, OP_CLEAR,       64'd0,                  4'(ST_OK)}
  };

  // ring predictor state
  logic [7:0]       ring_mem [CAPACITY];
  int unsigned      head_pos, tail_pos, peak_lvl;
  logic             bp_on, shut_seen;
  logic [CNT_W-1:0] n_in, n_out, n_drop, n_under;
  int unsigned      r_item, r_drop, r_locked, r_high, r_low;

  pending_t    due_q [$];
  int          err_count = 0;
  int          words_in = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          phase_no = -1;
  int          st_seen [8];
  int          stall_left = 0;
  int          calm_left = 0;

  function automatic void reset_model();
    head_pos  = 0;
    tail_pos  = 0;
    peak_lvl  = 0;
    bp_on     = 1'b0;
    shut_seen = 1'b0;
    n_in      = '0;
    n_out     = '0;
    n_drop    = '0;
    n_under   = '0;
    r_item    = 4;
    r_drop    = 0;
    r_locked  = 0;
    r_high    = HIGH_DEFAULT;
    r_low     = LOW_DEFAULT;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [8:0] val);
    case (idx)
      REG_ITEM_BYTES: r_item = val[3:0];
      REG_DROP_FULL:  r_drop = val[0];
      REG_LOCKED:     r_locked = val[0];
      REG_HIGH_MARK:  r_high = val;
      REG_LOW_MARK:   r_low = val;
      default: ;
    endcase
  endfunction

  function automatic int unsigned fill_level();
    return (head_pos - tail_pos) % (2 * CAPACITY);
  endfunction

  function automatic logic [63:0] fetch_bytes(input int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = ring_mem[IDX_W'(tail_pos + i)];
    return v;
  endfunction

  function automatic out_word_t ring_step(input in_word_t w);
    out_word_t   r;
    int unsigned n, hi, lo, lvl;
    r = '0;
    r.status = ST_OK;
    n = (r_item > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : r_item;
    hi = (r_high != 0) ? r_high : HIGH_DEFAULT;
    lo = (r_low != 0) ? r_low : LOW_DEFAULT;
    lvl = fill_level();
    if (n == 0 || w.op > OP_SHUTDOWN) begin
      r.status = ST_INVALID;
    end else begin
      case (w.op)
        OP_WRITE: begin
          if (CAPACITY - lvl < n) begin
            if (r_locked != 0 && shut_seen) begin
              r.status = ST_CANCEL;
            end else if (r_drop != 0) begin
              n_drop++;
              r.status = ST_FULL;
            end else begin
              r.status = ST_BLOCK;
            end
          end else begin
            for (int i = 0; i < n; i++)
              ring_mem[IDX_W'(head_pos + i)] = w.write_data[8*i +: 8];
            head_pos = (head_pos + n) % (2 * CAPACITY);
            n_in++;
            if (r_locked != 0) begin
              lvl = fill_level();
              if (lvl > peak_lvl) peak_lvl = lvl;
              if (lvl >= hi) bp_on = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (lvl < n) begin
            if (r_locked != 0) begin
              r.status = shut_seen ? ST_CANCEL : ST_BLOCK;
            end else begin
              n_under++;
              r.status = ST_EOF;
            end
          end else begin
            r.read_data = fetch_bytes(n);
            tail_pos = (tail_pos + n) % (2 * CAPACITY);
            n_out++;
            if (r_locked != 0 && fill_level() <= lo) bp_on = 1'b0;
          end
        end
        OP_PEEK: begin
          if (lvl < n) r.status = ST_EOF;
          else r.read_data = fetch_bytes(n);
        end
        OP_CLEAR: begin
          head_pos = 0;
          tail_pos = 0;
          bp_on = 1'b0;
        end
        default: shut_seen = 1'b1;
      endcase
    end
    r.used_bytes      = POS_W'(fill_level());
    r.backpressure    = bp_on;
    r.written_count   = n_in;
    r.read_count      = n_out;
    r.drop_count      = n_drop;
    r.underflow_count = n_under;
    r.peak_bytes      = POS_W'(peak_lvl);
    return r;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_result(input out_word_t got, input pending_t exp);
    out_word_t w;
    w = exp.word;
    if (exp.fixed != NO_STATUS && got.status !== exp.fixed[2:0])
      report_error($sformatf("status %0d, table says %0d", got.status, exp.fixed));
    if (got.status !== w.status)
      report_error($sformatf("status %0d, want %0d", got.status, w.status));
    if (got.read_data !== w.read_data)
      report_error($sformatf("read_data %h, want %h", got.read_data, w.read_data));
    if (got.used_bytes !== w.used_bytes)
      report_error($sformatf("used_bytes %0d, want %0d", got.used_bytes, w.used_bytes));
    if (got.backpressure !== w.backpressure)
      report_error($sformatf("backpressure %b, want %b", got.backpressure, w.backpressure));
    if (got.written_count !== w.written_count)
      report_error($sformatf("written_count %0d, want %0d", got.written_count,
                             w.written_count));
    if (got.read_count !== w.read_count)
      report_error($sformatf("read_count %0d, want %0d", got.read_count, w.read_count));
    if (got.drop_count !== w.drop_count)
      report_error($sformatf("drop_count %0d, want %0d", got.drop_count, w.drop_count));
    if (got.underflow_count !== w.underflow_count)
      report_error($sformatf("underflow_count %0d, want %0d", got.underflow_count,
                             w.underflow_count));
    if (got.peak_bytes !== w.peak_bytes)
      report_error($sformatf("peak_bytes %0d, want %0d", got.peak_bytes, w.peak_bytes));
  endtask

  // monitor: config and input words update the predictor, results are checked in order
  always @(posedge clk) begin
    pending_t p;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        p.fixed = in_fixed;
        p.word = ring_step(in_data);
        due_q.push_back(p);
        words_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        st_seen[out_data.status]++;
        if (due_q.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          p = due_q.pop_front();
          check_result(out_data, p);
        end
      end
    end
  end

  // receiver: random stalls, occasional long ones and calm stretches
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (choke) begin
      out_ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (r < 2) begin
      stall_left = $urandom_range(8, 40);
      out_ready <= 1'b0;
    end else if (r < 4) begin
      calm_left = $urandom_range(50, 200);
      out_ready <= 1'b1;
    end else begin
      out_ready <= (r >= 28);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (phase_no == 1);
    repeat (40) @(posedge clk);
    choke <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    choke <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] pick_mark();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 9'd0;
    if (r < 25) return 9'd1;
    if (r < 35) return 9'(CAPACITY);
    return 9'($urandom_range(1, CAPACITY));
  endfunction

  function automatic logic [63:0] pick_data();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] pick_op(input mix_t mix, input bit allow_shut);
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (allow_shut && r < 2) return OP_SHUTDOWN;
    case (mix)
      MIX_FILL:  op = (r < 87) ? OP_WRITE : (r < 95) ? OP_READ : (r < 99) ? OP_PEEK : OP_CLEAR;
      MIX_DRAIN: op = (r < 65) ? OP_READ : (r < 90) ? OP_PEEK : (r < 98) ? OP_WRITE : OP_CLEAR;
      MIX_BOTH:  op = (r < 45) ? OP_WRITE : (r < 80) ? OP_READ : (r < 98) ? OP_PEEK : OP_CLEAR;
      default: begin
        op = 3'($urandom_range(0, 7));
        if (op == OP_SHUTDOWN && !allow_shut) op = OP_PEEK;
      end
    endcase
    return op;
  endfunction

  task automatic offer(input in_word_t w, input logic [3:0] want, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    in_fixed <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [8:0] item, input logic [8:0] drop,
                           input logic [8:0] locked, input logic [8:0] high,
                           input logic [8:0] low);
    wait_idle();
    write_reg(REG_ITEM_BYTES, item, 1'b0);
    write_reg(REG_DROP_FULL, drop, 1'b0);
    write_reg(REG_LOCKED, locked, 1'b0);
    write_reg(REG_HIGH_MARK, high, 1'b0);
    write_reg(REG_LOW_MARK, low, 1'b1);
  endtask

  // bursts of fill, drain, mixed or noise traffic with random content
  task automatic run_phase(input int count, input bit allow_shut);
    in_word_t w;
    mix_t     mix;
    int       left, r;
    bit       calm;
    left = 0;
    mix = MIX_FILL;
    calm = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < count; k++) begin
      if (left == 0) begin
        r = $urandom_range(0, 9);
        mix = (r < 4) ? MIX_FILL : (r < 7) ? MIX_DRAIN : (r < 9) ? MIX_BOTH : MIX_NOISE;
        left = $urandom_range(4, 80);
        calm = ($urandom_range(0, 4) == 0);
      end
      left--;
      w.op = pick_op(mix, allow_shut);
      w.write_data = pick_data();
      offer(w, NO_STATUS, pick_gap(calm));
    end
  endtask

  initial begin
    in_word_t w;
    bit last;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NPLAN; i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        last = (i == NPLAN - 1) ? 1'b1 : !plan[i+1].is_cfg;
        write_reg(plan[i].code, plan[i].val[8:0], last);
      end else begin
        w.op = plan[i].code;
        w.write_data = plan[i].val;
        offer(w, plan[i].want, pick_gap(1'b0));
      end
    end

    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: configure(9'd8, 9'd0, 9'd0, 9'd0, 9'd0);
        1: configure(9'd8, 9'd1, 9'd1, 9'(CAPACITY), 9'd1);
        2: configure(9'd15, 9'd0, 9'd1, 9'd1, 9'(CAPACITY));
        3: configure(9'd3, 9'd1, 9'd0, pick_mark(), pick_mark());
        4: configure(9'd0, 9'd1, 9'd1, 9'd0, 9'd0);
        5: configure(9'd1, 9'd0, 9'd1, pick_mark(), pick_mark());
        6: configure(9'd5, 9'd1, 9'd1, pick_mark(), pick_mark());
        7: configure(9'($urandom_range(1, 15)), 9'($urandom_range(0, 1)),
                     9'($urandom_range(0, 1)), pick_mark(), pick_mark());
        8: configure(9'd7, 9'd1, 9'd1, pick_mark(), pick_mark());
        default: configure(9'd8, 9'd0, 9'd1, pick_mark(), pick_mark());
      endcase
      phase_no = p;
      // shutdown is sticky, so it only shows up in the closing phases
      run_phase((p == 4) ? 30 : 190, p >= 7);
    end

    wait_idle();
    $display("run: %0d words in, %0d results checked, %0d register writes, %0d phases",
             words_in, results_seen, reg_writes, NPHASE);
    $display("status mix: ok %0d invalid %0d full %0d block %0d eof %0d cancel %0d",
             st_seen[ST_OK], st_seen[ST_INVALID], st_seen[ST_FULL], st_seen[ST_BLOCK],
             st_seen[ST_EOF], st_seen[ST_CANCEL]);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
